>>> rtl/g2e_pkg.sv
// Shared types, fixed-point constants and elaboration-time helper functions
// for the geodetic to ECEF conversion pipeline. No dependencies.
package g2e_pkg;

  typedef logic [63:0]        q60_t;
  typedef logic signed [63:0] sq60_t;

  // Q60 fixed-point constants.
  localparam q60_t ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam q60_t PI_Q60      = 64'h3243_F6A8_885A_308D;
  localparam q60_t DEG2RAD_Q60 = (PI_Q60 + 64'd90) / 64'd180;

  // Field widths.
  localparam int LAT_W      = 32;
  localparam int LON_W      = 33;
  localparam int HGT_W      = 28;
  localparam int OUT_W      = 34;
  localparam int AXIS_W     = 33;
  localparam int ECC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 33;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_AXIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECC  = 2'd1;

  // Pipeline depth: the angle unit adds this many stages to its rotation
  // steps, and the radius and output path adds POST_LAT stages after it.
  localparam int CORDIC_EXTRA = 5;
  localparam int POST_LAT     = 64;

  // (a*b) >> sh, rounded half up, saturating to 64 bits.
  function automatic q60_t mulq_c(q60_t a, q60_t b, int unsigned sh);
    logic [127:0] p;
    logic [127:0] s;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
    s = p >> sh;
    if (|s[127:64]) return '1;
    return s[63:0];
  endfunction

  // atan(2^-i) in Q60 as a truncated alternating series.
  function automatic sq60_t atan_c(int unsigned i);
    sq60_t       acc;
    q60_t        v;
    q60_t        t;
    int unsigned e;
    acc = '0;
    if (i == 0) return $signed(PI_Q60 >> 2);
    for (int k = 0; k < 30; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        v = ONE_Q60 >> e;
        case (k)
          0:  t = v;
          1:  t = v / 64'd3;
          2:  t = v / 64'd5;
          3:  t = v / 64'd7;
          4:  t = v / 64'd9;
          5:  t = v / 64'd11;
          6:  t = v / 64'd13;
          7:  t = v / 64'd15;
          8:  t = v / 64'd17;
          9:  t = v / 64'd19;
          10: t = v / 64'd21;
          11: t = v / 64'd23;
          12: t = v / 64'd25;
          13: t = v / 64'd27;
          14: t = v / 64'd29;
          15: t = v / 64'd31;
          16: t = v / 64'd33;
          17: t = v / 64'd35;
          18: t = v / 64'd37;
          19: t = v / 64'd39;
          20: t = v / 64'd41;
          21: t = v / 64'd43;
          22: t = v / 64'd45;
          23: t = v / 64'd47;
          24: t = v / 64'd49;
          25: t = v / 64'd51;
          26: t = v / 64'd53;
          27: t = v / 64'd55;
          28: t = v / 64'd57;
          29: t = v / 64'd59;
          default: t = '0;
        endcase
        if (k[0]) acc = acc - $signed(t);
        else      acc = acc + $signed(t);
      end
    end
    return acc;
  endfunction

  // Rotation gain correction for a given step count, in Q60.
  function automatic sq60_t gain_c(int unsigned steps);
    q60_t p;
    q60_t v;
    q60_t k;
    q60_t m;
    q60_t t;
    q60_t r;
    int   e;
    p = ONE_Q60;
    e = 0;
    for (int i = 0; i < 64; i++) begin
      if (i < steps && 2 * i < 64) p = p + (p >> (2 * i));
    end
    v = p;
    if (v == '0) v = 64'd1;
    for (int j = 0; j < 32; j++) begin
      if (v < (ONE_Q60 >> 2)) begin
        v = v << 2;
        e = e + 1;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (v > ONE_Q60) begin
        v = v >> 2;
        e = e - 1;
      end
    end
    k = (64'd5 << 59) - mulq_c(v, 64'd3 << 59, 60);
    for (int n = 0; n < 8; n++) begin
      m = mulq_c(v, mulq_c(k, k, 60), 60);
      t = (m < 3 * ONE_Q60) ? 3 * ONE_Q60 - m : '0;
      k = mulq_c(k, t, 61);
    end
    r = k;
    if (e < 0)      r = (-e < 64) ? k >> (-e) : '0;
    else if (e > 0) r = (e < 3) ? k << e : ONE_Q60;
    return $signed(r);
  endfunction

endpackage

>>> rtl/g2e_mulq.sv
// Two-stage unsigned 64x64 multiplier with a rounded right shift and
// saturation to 64 bits. Depends on g2e_pkg.
module g2e_mulq import g2e_pkg::*; #(
  parameter int unsigned SHIFT = 60
) (
  input  logic clk,
  input  q60_t a,
  input  q60_t b,
  output q60_t p
);

  localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

  q60_t         p00_r, p01_r, p10_r, p11_r, p_r, p_nxt;
  logic [127:0] sum, shifted;

  // First stage: four 32x32 partial products.
  always_ff @(posedge clk) begin
    p00_r <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    p01_r <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    p10_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    p11_r <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
  end

  // Second stage: merge, round half up, shift and saturate.
  always_comb begin
    sum = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
        + {p11_r, 64'd0} + RND;
    shifted = sum >> SHIFT;
    p_nxt = (|shifted[127:64]) ? '1 : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

>>> rtl/g2e_cordic.sv
// Pipelined sine and cosine of an angle in degrees (24 fraction bits):
// range reduction, degree to radian scaling, one rotation step per stage.
// Depends on g2e_pkg and g2e_mulq.
module g2e_cordic import g2e_pkg::*; #(
  parameter int STEPS   = 32,
  parameter int ANGLE_W = 33
) (
  input  logic                      clk,
  input  logic signed [ANGLE_W-1:0] angle,
  output sq60_t                     sin_q,
  output sq60_t                     cos_q
);

  localparam logic signed [34:0] FULL    = 35'sd6039797760;
  localparam logic signed [34:0] HALF    = 35'sd3019898880;
  localparam logic signed [34:0] QUARTER = 35'sd1509949440;
  localparam sq60_t GAIN  = gain_c(STEPS);
  localparam sq60_t ONE_S = $signed(ONE_Q60);

  logic signed [34:0] shifted, wrap_nxt, wrap_r, folded;
  logic               flip_nxt, flip_r, neg_r;
  logic [30:0]        mag_r;
  logic [1:0]         neg_d_r;
  logic [STEPS+1:0]   flip_d_r;
  q60_t               zmag;
  sq60_t              x_r [STEPS];
  sq60_t              y_r [STEPS];
  sq60_t              z_r [STEPS];
  sq60_t              xc, yc, sin_r, cos_r;

  // Wrap into [-180, 180) degrees; one correction covers the input range.
  always_comb begin
    shifted = 35'(angle) + HALF;
    if (shifted < 0)          wrap_nxt = shifted + FULL - HALF;
    else if (shifted >= FULL) wrap_nxt = shifted - FULL - HALF;
    else                      wrap_nxt = shifted - HALF;
  end

  // Fold into [-90, 90] degrees; a fold negates the cosine.
  always_comb begin
    folded   = wrap_r;
    flip_nxt = 1'b0;
    if (wrap_r > QUARTER) begin
      folded   = HALF - wrap_r;
      flip_nxt = 1'b1;
    end else if (wrap_r < -QUARTER) begin
      folded   = -HALF - wrap_r;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wrap_r   <= wrap_nxt;
    mag_r    <= folded[34] ? 31'(-folded) : folded[30:0];
    neg_r    <= folded[34];
    flip_r   <= flip_nxt;
    neg_d_r  <= {neg_d_r[0], neg_r};
    flip_d_r <= {flip_d_r[STEPS:0], flip_r};
  end

  // Degrees to radians in Q60.
  g2e_mulq #(.SHIFT(24)) u_d2r (
    .clk (clk),
    .a   ({33'd0, mag_r}),
    .b   (DEG2RAD_Q60),
    .p   (zmag)
  );

  // Rotation steps, one per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam sq60_t ATAN = atan_c(i);
    sq60_t xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = neg_d_r[1] ? -$signed(zmag) : $signed(zmag);
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!zi[63]) begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
        z_r[i] <= zi - ATAN;
      end else begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
        z_r[i] <= zi + ATAN;
      end
    end
  end

  // Clamp to unit magnitude and apply the fold to the cosine.
  always_comb begin
    xc = x_r[STEPS-1];
    yc = y_r[STEPS-1];
    if (xc > ONE_S)  xc = ONE_S;
    if (xc < -ONE_S) xc = -ONE_S;
    if (yc > ONE_S)  yc = ONE_S;
    if (yc < -ONE_S) yc = -ONE_S;
  end

  always_ff @(posedge clk) begin
    sin_r <= yc;
    cos_r <= flip_d_r[STEPS+1] ? -xc : xc;
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

>>> rtl/geodetic_to_ecef_unit.sv
// Geodetic (latitude, longitude, height) to ECEF X, Y, Z conversion pipeline.
// Depends on g2e_pkg, g2e_mulq and g2e_cordic.
//
// The unit takes one item per clock while start is high and busy is low; busy
// is high only during reset. Each item's result appears as a single-cycle
// out_valid strobe; the receiver must take it in that cycle. The result path
// runs through the rotation steps of the angle units (one per stage) and the
// eight Newton iterations of the inverse square root, each three two-stage
// multiplies long. The configuration port is always ready; write the axis and
// eccentricity registers only while no item is in flight.
module geodetic_to_ecef_unit import g2e_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [LAT_W-1:0] in_latitude,
  input  logic signed [LON_W-1:0] in_longitude,
  input  logic signed [HGT_W-1:0] in_height_mm,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_ecef_x,
  output logic signed [OUT_W-1:0] out_ecef_y,
  output logic signed [OUT_W-1:0] out_ecef_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int   TC           = CORDIC_STEPS + CORDIC_EXTRA;
  localparam int   PIPE_LAT     = TC + POST_LAT;
  localparam int   HGT_DLY      = TC + 60;
  localparam int   TRIG_DLY     = 59;
  localparam int   SIN_DLY      = 61;
  localparam int   NEWTON_ITERS = 8;
  localparam q60_t THREE_Q60    = 64'h3000_0000_0000_0000;
  localparam q60_t N_CAP        = 64'h0100_0000_0000_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sd8589934591;
  localparam logic signed [63:0] OUT_MIN = -64'sd8589934592;

  logic                busy_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic [AXIS_W-1:0]   axis_r;
  logic [ECC_W-1:0]    ecc_r;

  // Round half up from 16 fraction bits and saturate to the output range.
  function automatic logic signed [OUT_W-1:0] to_out(logic neg, q60_t mag);
    logic signed [63:0] v;
    v = neg ? -$signed(mag) : $signed(mag);
    v = (v + 64'sd32768) >>> 16;
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // Control: busy during reset only, and a valid bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_LAT-2:0], start & ~busy_r};
    end
  end

  assign busy      = busy_r;
  assign out_valid = vld_r[PIPE_LAT-1];
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= 33'd6378137000;
      ecc_r  <= 32'd28752143;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AXIS: axis_r <= cfg_data;
        REG_ECC:  ecc_r  <= cfg_data[ECC_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sine and cosine of both angles.
  sq60_t sl, cl, so, co;

  g2e_cordic #(.STEPS(CORDIC_STEPS), .ANGLE_W(LAT_W)) u_lat (
    .clk (clk), .angle (in_latitude), .sin_q (sl), .cos_q (cl)
  );

  g2e_cordic #(.STEPS(CORDIC_STEPS), .ANGLE_W(LON_W)) u_lon (
    .clk (clk), .angle (in_longitude), .sin_q (so), .cos_q (co)
  );

  // sin^2 of latitude, then e2 * sin^2.
  q60_t us, s2, s2c, q_w;
  assign us  = sl[63] ? q60_t'(-sl) : q60_t'(sl);
  assign s2c = (s2 > ONE_Q60) ? ONE_Q60 : s2;

  g2e_mulq #(.SHIFT(60)) u_s2 (.clk (clk), .a (us), .b (us), .p (s2));
  g2e_mulq #(.SHIFT(60)) u_eq (.clk (clk), .a ({4'd0, ecc_r, 28'd0}), .b (s2c), .p (q_w));

  // Normalize 1 - e2 sin^2 into [1/4, 1] by pairs of bits, over two stages.
  q60_t       d1, v1_nxt, v2_nxt, nv1_r, nv2_r, nv3_r, k0_r;
  logic [4:0] e1_nxt, e2_nxt, ne1_r, ne2_r, ne3_r;

  always_comb begin
    d1 = ONE_Q60 - q_w;
    if (d1 == '0) d1 = 64'd1;
    v1_nxt = d1;
    e1_nxt = '0;
    if (v1_nxt < (64'd1 << 28)) begin
      v1_nxt = v1_nxt << 32;
      e1_nxt = e1_nxt + 5'd16;
    end
    if (v1_nxt < (64'd1 << 44)) begin
      v1_nxt = v1_nxt << 16;
      e1_nxt = e1_nxt + 5'd8;
    end
  end

  always_comb begin
    v2_nxt = nv1_r;
    e2_nxt = ne1_r;
    if (v2_nxt < (64'd1 << 52)) begin
      v2_nxt = v2_nxt << 8;
      e2_nxt = e2_nxt + 5'd4;
    end
    if (v2_nxt < (64'd1 << 56)) begin
      v2_nxt = v2_nxt << 4;
      e2_nxt = e2_nxt + 5'd2;
    end
    if (v2_nxt < (64'd1 << 58)) begin
      v2_nxt = v2_nxt << 2;
      e2_nxt = e2_nxt + 5'd1;
    end
  end

  // Initial estimate k0 = 5/2 - 3v/2 in Q60.
  always_ff @(posedge clk) begin
    nv1_r <= v1_nxt;
    ne1_r <= e1_nxt;
    nv2_r <= v2_nxt;
    ne2_r <= e2_nxt;
    nv3_r <= nv2_r;
    ne3_r <= ne2_r;
    k0_r  <= (64'd5 << 59) - ((3 * nv2_r + 64'd1) >> 1);
  end

  // Newton iterations of the inverse square root, six stages each.
  wire q60_t       nk [NEWTON_ITERS+1];
  wire q60_t       nv [NEWTON_ITERS+1];
  wire logic [4:0] ne [NEWTON_ITERS+1];

  assign nk[0] = k0_r;
  assign nv[0] = nv3_r;
  assign ne[0] = ne3_r;

  for (genvar j = 0; j < NEWTON_ITERS; j++) begin : g_newton
    q60_t       kk_w, mm_w, tt_w;
    q60_t       k_d_r [4];
    q60_t       v_d_r [6];
    logic [4:0] e_d_r [6];

    g2e_mulq #(.SHIFT(60)) u_kk (.clk (clk), .a (nk[j]), .b (nk[j]), .p (kk_w));

    always_ff @(posedge clk) begin
      k_d_r[0] <= nk[j];
      v_d_r[0] <= nv[j];
      e_d_r[0] <= ne[j];
      for (int s = 1; s < 4; s++) k_d_r[s] <= k_d_r[s-1];
      for (int s = 1; s < 6; s++) begin
        v_d_r[s] <= v_d_r[s-1];
        e_d_r[s] <= e_d_r[s-1];
      end
    end

    g2e_mulq #(.SHIFT(60)) u_m (.clk (clk), .a (v_d_r[1]), .b (kk_w), .p (mm_w));

    assign tt_w = (mm_w < THREE_Q60) ? THREE_Q60 - mm_w : '0;

    g2e_mulq #(.SHIFT(61)) u_k (.clk (clk), .a (k_d_r[3]), .b (tt_w), .p (nk[j+1]));

    assign nv[j+1] = v_d_r[5];
    assign ne[j+1] = e_d_r[5];
  end

  // Prime-vertical radius N in mm with 16 fraction bits, capped at 2^40 mm.
  q60_t       nraw, n_nxt, n_r, r2m;
  q60_t       n_d_r [2];
  logic [4:0] ef_d_r [2];

  g2e_mulq #(.SHIFT(44)) u_n (
    .clk (clk), .a ({31'd0, axis_r}), .b (nk[NEWTON_ITERS]), .p (nraw)
  );

  always_comb begin
    if (nraw > (N_CAP >> ef_d_r[1])) n_nxt = N_CAP;
    else                             n_nxt = nraw << ef_d_r[1];
    if (n_nxt > N_CAP) n_nxt = N_CAP;
  end

  always_ff @(posedge clk) begin
    ef_d_r[0] <= ne[NEWTON_ITERS];
    ef_d_r[1] <= ef_d_r[0];
    n_r       <= n_nxt;
    n_d_r[0]  <= n_r;
    n_d_r[1]  <= n_d_r[0];
  end

  // N (1 - e2).
  g2e_mulq #(.SHIFT(32)) u_r2 (
    .clk (clk), .a (n_r), .b ({31'd0, 33'h1_0000_0000 - {1'b0, ecc_r}}), .p (r2m)
  );

  // Height aligned with the radius terms.
  logic signed [HGT_W-1:0] h_d_r [HGT_DLY];
  logic signed [63:0]      h16, r1_r, r2_r;

  always_ff @(posedge clk) begin
    h_d_r[0] <= in_height_mm;
    for (int s = 1; s < HGT_DLY; s++) h_d_r[s] <= h_d_r[s-1];
  end

  assign h16 = {{(64 - HGT_W - 16){h_d_r[HGT_DLY-1][HGT_W-1]}}, h_d_r[HGT_DLY-1], 16'd0};

  always_ff @(posedge clk) begin
    r1_r <= $signed(n_d_r[1]) + h16;
    r2_r <= $signed(r2m) + h16;
  end

  // cos lat cos lon and cos lat sin lon, rounded on magnitude.
  q60_t  acl, aco, aso, pcc, pcs;
  logic  scc_d_r [2];
  logic  scs_d_r [2];
  sq60_t cc_d_r [TRIG_DLY];
  sq60_t cs_d_r [TRIG_DLY];
  sq60_t sl_d_r [SIN_DLY];

  assign acl = cl[63] ? q60_t'(-cl) : q60_t'(cl);
  assign aco = co[63] ? q60_t'(-co) : q60_t'(co);
  assign aso = so[63] ? q60_t'(-so) : q60_t'(so);

  g2e_mulq #(.SHIFT(60)) u_cc (.clk (clk), .a (acl), .b (aco), .p (pcc));
  g2e_mulq #(.SHIFT(60)) u_cs (.clk (clk), .a (acl), .b (aso), .p (pcs));

  always_ff @(posedge clk) begin
    scc_d_r[0] <= cl[63] ^ co[63];
    scc_d_r[1] <= scc_d_r[0];
    scs_d_r[0] <= cl[63] ^ so[63];
    scs_d_r[1] <= scs_d_r[0];
    cc_d_r[0]  <= scc_d_r[1] ? -$signed(pcc) : $signed(pcc);
    cs_d_r[0]  <= scs_d_r[1] ? -$signed(pcs) : $signed(pcs);
    for (int s = 1; s < TRIG_DLY; s++) begin
      cc_d_r[s] <= cc_d_r[s-1];
      cs_d_r[s] <= cs_d_r[s-1];
    end
    sl_d_r[0] <= sl;
    for (int s = 1; s < SIN_DLY; s++) sl_d_r[s] <= sl_d_r[s-1];
  end

  // Final products: radius times trig factor, sign carried beside.
  sq60_t fx, fy, fz;
  q60_t  ar1, ar2, afx, afy, afz, px, py, pz;
  logic  sx_d_r [2];
  logic  sy_d_r [2];
  logic  sz_d_r [2];

  assign fx  = cc_d_r[TRIG_DLY-1];
  assign fy  = cs_d_r[TRIG_DLY-1];
  assign fz  = sl_d_r[SIN_DLY-1];
  assign ar1 = r1_r[63] ? q60_t'(-r1_r) : q60_t'(r1_r);
  assign ar2 = r2_r[63] ? q60_t'(-r2_r) : q60_t'(r2_r);
  assign afx = fx[63] ? q60_t'(-fx) : q60_t'(fx);
  assign afy = fy[63] ? q60_t'(-fy) : q60_t'(fy);
  assign afz = fz[63] ? q60_t'(-fz) : q60_t'(fz);

  g2e_mulq #(.SHIFT(60)) u_px (.clk (clk), .a (ar1), .b (afx), .p (px));
  g2e_mulq #(.SHIFT(60)) u_py (.clk (clk), .a (ar1), .b (afy), .p (py));
  g2e_mulq #(.SHIFT(60)) u_pz (.clk (clk), .a (ar2), .b (afz), .p (pz));

  logic signed [OUT_W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    sx_d_r[0] <= r1_r[63] ^ fx[63];
    sx_d_r[1] <= sx_d_r[0];
    sy_d_r[0] <= r1_r[63] ^ fy[63];
    sy_d_r[1] <= sy_d_r[0];
    sz_d_r[0] <= r2_r[63] ^ fz[63];
    sz_d_r[1] <= sz_d_r[0];
    x_r       <= to_out(sx_d_r[1], px);
    y_r       <= to_out(sy_d_r[1], py);
    z_r       <= to_out(sz_d_r[1], pz);
  end

  assign out_ecef_x = x_r;
  assign out_ecef_y = y_r;
  assign out_ecef_z = z_r;

endmodule

>>> rtl/g2e_checker.sv
// Port-level checks of the conversion unit's fixed latency and reset behavior,
// bound to geodetic_to_ecef_unit. Depends on g2e_pkg for the pipeline depth.
module g2e_checker #(
  parameter int LATENCY = 101
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_latitude,
  input logic [32:0] in_longitude,
  input logic [27:0] in_height_mm,
  input logic        out_valid,
  input logic [33:0] out_ecef_x,
  input logic [33:0] out_ecef_y,
  input logic [33:0] out_ecef_z,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [32:0] cfg_data
);

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] since_rst_r;

  // Cycles since reset, saturating at the pipeline depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else if (since_rst_r != CNT_W'(LATENCY)) begin
      since_rst_r <= since_rst_r + 1'b1;
    end
  end

  // Every result strobe traces back to an item taken a fixed time before.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching item");

  // Every item taken after reset produces its result at the fixed latency.
  a_item_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r == CNT_W'(LATENCY) && $past(start && !busy, LATENCY)) |-> out_valid)
    else $error("item taken but no result strobe");

  // The unit can take an item in every cycle once out of reset.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind geodetic_to_ecef_unit g2e_checker #(
  .LATENCY(CORDIC_STEPS + g2e_pkg::CORDIC_EXTRA + g2e_pkg::POST_LAT)
) u_g2e_checker (.*);

>>> sim/tb_geodetic_to_ecef_unit.sv
// Self-checking testbench for geodetic_to_ecef_unit: a bit-exact predictor of
// the CORDIC, inverse-root and rounding arithmetic checks every X, Y, Z item.
// Depends on g2e_pkg and the RTL of geodetic_to_ecef_unit.
module tb_geodetic_to_ecef_unit;
  import g2e_pkg::*;

  localparam int    LATENCY   = 32 + 69;
  localparam int    SETTLE    = LATENCY + 20;
  localparam int    WDOG_MAX  = 3000;
  localparam longint DEG_Q24  = 16777216;
  localparam longint OUT_HI   = 64'sd8589934591;
  localparam longint OUT_LO   = -64'sd8589934592;
  localparam logic [63:0] RADIUS_CAP = 64'd1 << 56;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [HGT_W-1:0] hgt;
  } position_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } ecef_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [LAT_W-1:0] in_latitude = '0;
  logic signed [LON_W-1:0] in_longitude = '0;
  logic signed [HGT_W-1:0] in_height_mm = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_ecef_x, out_ecef_y, out_ecef_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  position_t   position_q[$];
  ecef_t       ecef_q[$];
  position_t   cur_pos;
  logic [AXIS_W-1:0] axis_mm = 33'd6378137000;
  logic [ECC_W-1:0]  ecc_frac = 32'd28752143;
  longint      atan_tbl[32];
  longint      rot_gain;
  int          gap_left = 0;
  bit          steady = 1'b0;
  int          fail_cnt = 0;
  int          quiet_cycles = 0;

  geodetic_to_ecef_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Product shifted right with half-up rounding, saturating to 64 bits.
  function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
    p = p >> sh;
    if (|p[127:64]) return '1;
    return p[63:0];
  endfunction

  // Signed product: rounding on the magnitude, so half away from zero.
  function automatic longint mul_sgn(longint a, longint b, int unsigned sh);
    logic [63:0] ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = mul_rnd(ua, ub, sh);
    if (p > 64'h7FFF_FFFF_FFFF_FFFF) p = 64'h7FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  function automatic longint arctan_step(int unsigned i);
    longint acc;
    longint t;
    longint unsigned e;
    acc = 0;
    if (i == 0) return $signed(PI_Q60 >> 2);
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      t = $signed((ONE_Q60 >> e) / (2 * k + 1));
      acc = k[0] ? acc - t : acc + t;
    end
    return acc;
  endfunction

  // Normalised Newton inverse root; true value is result * 2^expo.
  function automatic logic [63:0] inv_root(logic [63:0] v, output int expo);
    logic [63:0] k, m, t;
    expo = 0;
    if (v == 0) v = 1;
    while (v < (ONE_Q60 >> 2)) begin
      v = v << 2;
      expo++;
    end
    while (v > ONE_Q60) begin
      v = v >> 2;
      expo--;
    end
    k = (64'd5 << 59) - mul_rnd(v, 64'd3 << 59, 60);
    for (int n = 0; n < 8; n++) begin
      m = mul_rnd(v, mul_rnd(k, k, 60), 60);
      t = (m < 3 * ONE_Q60) ? 3 * ONE_Q60 - m : 64'd0;
      k = mul_rnd(k, t, 61);
    end
    return k;
  endfunction

  function automatic longint rotation_gain();
    logic [63:0] p, r;
    int e;
    p = ONE_Q60;
    for (int i = 0; i < 32; i++) p = p + (p >> (2 * i));
    r = inv_root(p, e);
    if (e < 0) r = (-e < 64) ? r >> (-e) : 64'd0;
    else if (e > 0) r = (e < 3) ? r << e : ONE_Q60;
    return $signed(r);
  endfunction

  // Sine and cosine of an angle in Q24 degrees, after wrapping into [-180, 180).
  task automatic sin_cos(longint deg, output longint sn, output longint cs);
    longint full, half, quarter, a, x, y, z, dx, dy;
    logic [63:0] mag;
    bit flip;
    full = 360 * DEG_Q24;
    half = 180 * DEG_Q24;
    quarter = 90 * DEG_Q24;
    a = ((deg + half) % full + full) % full - half;
    flip = 1'b0;
    if (a > quarter) begin
      a = half - a;
      flip = 1'b1;
    end else if (a < -quarter) begin
      a = -half - a;
      flip = 1'b1;
    end
    mag = (a < 0) ? -a : a;
    z = $signed(mul_rnd(mag, DEG2RAD_Q60, 24));
    if (a < 0) z = -z;
    x = rot_gain;
    y = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tbl[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tbl[i];
      end
    end
    if (x > $signed(ONE_Q60)) x = $signed(ONE_Q60);
    if (x < -$signed(ONE_Q60)) x = -$signed(ONE_Q60);
    if (y > $signed(ONE_Q60)) y = $signed(ONE_Q60);
    if (y < -$signed(ONE_Q60)) y = -$signed(ONE_Q60);
    sn = y;
    cs = flip ? -x : x;
  endtask

  function automatic logic [OUT_W-1:0] scale_mm(longint r_q16, longint f_q60);
    longint v;
    v = (mul_sgn(r_q16, f_q60, 60) + 32768) >>> 16;
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[OUT_W-1:0];
  endfunction

  task automatic predict_ecef(position_t p, output ecef_t res);
    longint lat, lon, hgt, sl, cl, so, co, h16, r1, r2;
    logic [63:0] us, s2, d, r, n;
    int e;
    lat = p.lat;
    lon = p.lon;
    hgt = p.hgt;
    sin_cos(lat, sl, cl);
    sin_cos(lon, so, co);
    us = (sl < 0) ? -sl : sl;
    s2 = mul_rnd(us, us, 60);
    if (s2 > ONE_Q60) s2 = ONE_Q60;
    d = ONE_Q60 - mul_rnd({32'd0, ecc_frac} << 28, s2, 60);
    if (d == 0) d = 1;
    r = inv_root(d, e);
    n = mul_rnd({31'd0, axis_mm}, r, 44);
    if (e > 0) begin
      if (e > 56 || n > (RADIUS_CAP >> e)) n = RADIUS_CAP;
      else n = n << e;
    end else if (e < 0) begin
      n = (-e < 64) ? n >> (-e) : 64'd0;
    end
    if (n > RADIUS_CAP) n = RADIUS_CAP;
    h16 = hgt * 65536;
    r1 = $signed(n) + h16;
    r2 = $signed(mul_rnd(n, (64'd1 << 32) - {32'd0, ecc_frac}, 32)) + h16;
    res.x = scale_mm(r1, mul_sgn(cl, co, 60));
    res.y = scale_mm(r1, mul_sgn(cl, so, 60));
    res.z = scale_mm(r2, sl);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: takes items from the position queue, with random gaps between them unless steady is set.
  always @(posedge clk) begin
    ecef_t exp_res;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_ecef(cur_pos, exp_res);
        ecef_q.push_back(exp_res);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (position_q.size() > 0) begin
          cur_pos = position_q.pop_front();
          in_latitude <= cur_pos.lat;
          in_longitude <= cur_pos.lon;
          in_height_mm <= cur_pos.hgt;
          start <= 1'b1;
          gap_left <= steady ? 0 : pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    ecef_t want;
    if (rst_n && out_valid) begin
      if (ecef_q.size() == 0) begin
        $display("%0t: result with no item pending: x=%0d y=%0d z=%0d", $time,
                 out_ecef_x, out_ecef_y, out_ecef_z);
        fail_cnt++;
      end else begin
        want = ecef_q.pop_front();
        if (out_ecef_x !== want.x) begin
          $display("%0t: ecef_x expected %0d actual %0d", $time, want.x, out_ecef_x);
          fail_cnt++;
        end
        if (out_ecef_y !== want.y) begin
          $display("%0t: ecef_y expected %0d actual %0d", $time, want.y, out_ecef_y);
          fail_cnt++;
        end
        if (out_ecef_z !== want.z) begin
          $display("%0t: ecef_z expected %0d actual %0d", $time, want.z, out_ecef_z);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no handshake at all.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("tb_geodetic_to_ecef_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_AXIS) axis_mm = val[AXIS_W-1:0];
    else if (idx == REG_ECC) ecc_frac = val[ECC_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pos(longint lat, longint lon, longint hgt);
    position_t p;
    p.lat = lat[LAT_W-1:0];
    p.lon = lon[LON_W-1:0];
    p.hgt = hgt[HGT_W-1:0];
    position_q.push_back(p);
  endtask

  // Mostly realistic positions, some with every field bit random.
  task automatic add_random(int count);
    logic [63:0] w;
    longint lat, lon, hgt;
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) begin
        lat = longint'($urandom_range(0, 32'd3019898880)) - 64'sd1509949440;
        w = {$urandom, $urandom};
        lon = longint'(w % 64'd6039797761) - 64'sd3019898880;
        hgt = longint'($urandom_range(0, 110000000)) - 10000000;
      end else begin
        lat = longint'({$urandom, $urandom});
        lon = longint'({$urandom, $urandom});
        hgt = longint'({$urandom, $urandom});
      end
      add_pos(lat, lon, hgt);
    end
  endtask

  task automatic drain();
    while (position_q.size() > 0 || start || ecef_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    longint d90;
    logic [63:0] w;
    d90 = 90 * DEG_Q24;
    for (int i = 0; i < 32; i++) atan_tbl[i] = arctan_step(i);
    rot_gain = rotation_gain();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: poles, equator, wraps, field extremes and angles past the poles.
    add_pos(0, 0, 0);
    add_pos(d90, 0, 0);
    add_pos(-d90, 0, 0);
    add_pos(0, 2 * d90, 0);
    add_pos(0, -2 * d90, 0);
    add_pos(0, 2 * d90 - 1, 0);
    add_pos(d90 / 2, d90, 100000000);
    add_pos(-d90 / 2, -d90, -10000000);
    add_pos(64'sd2147483647, 64'sd4294967295, 64'sd134217727);
    add_pos(-64'sd2147483648, -64'sd4294967296, -64'sd134217728);
    add_pos(d90 + d90 / 9, 3 * d90, 5000);
    add_pos(-d90 - d90 / 2, -6 * d90, -5000);
    add_pos(d90 / 3, 4 * d90, 12345);
    add_pos(-d90 / 3, 2 * d90 / 3, 8848000);
    add_pos(d90 - 1, -d90 + 1, 1);
    add_pos(-1, 1, -1);
    add_pos(2 * d90, 0, 0);
    add_random(90);
    drain();

    // Lower extremes, plus writes to unused indexes that must be ignored.
    reg_write(REG_AXIS, 33'd0);
    reg_write(REG_ECC, 33'd0);
    reg_write(2'd2, 33'h1_2345_6789);
    reg_write(2'd3, '1);
    add_pos(d90 / 2, d90 / 2, 100000000);
    add_random(80);
    drain();

    // Upper extremes: eccentricity near one pushes the radius toward its cap.
    reg_write(REG_AXIS, 33'd8000000000);
    reg_write(REG_ECC, 33'h1_FFFF_FFFF);
    add_pos(d90, 0, 0);
    add_pos(d90 / 2, d90, 0);
    add_random(80);
    drain();

    reg_write(REG_AXIS, '1);
    reg_write(REG_ECC, 33'd1);
    add_random(70);
    drain();

    // Random settings, the first with back-to-back items.
    for (int ph = 0; ph < 2; ph++) begin
      w = {$urandom, $urandom};
      reg_write(REG_AXIS, CFG_DATA_W'(w % 64'd8000000001));
      reg_write(REG_ECC, {1'b0, $urandom});
      steady = (ph == 0);
      add_random(80);
      drain();
    end
    steady = 1'b0;

    reg_write(REG_AXIS, 33'd6378137000);
    reg_write(REG_ECC, 33'd28752143);
    add_random(70);
    drain();

    if (fail_cnt == 0) begin
      $display("tb_geodetic_to_ecef_unit: PASS");
    end else begin
      $display("tb_geodetic_to_ecef_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/g2e_pkg.sv
rtl/g2e_mulq.sv
rtl/g2e_cordic.sv
rtl/geodetic_to_ecef_unit.sv
rtl/g2e_checker.sv
sim/tb_geodetic_to_ecef_unit.sv
